// ----- design/voxel_region_editor_unit_macros.svh -----
// Assertion macros used by the voxel region editor datapath.
`ifndef VOXEL_REGION_EDITOR_UNIT_MACROS_SVH
`define VOXEL_REGION_EDITOR_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define VREU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voxel region editor: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define VREU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voxel region editor: next-cycle check failed");

`endif

// ----- design/vreu_pkg.sv -----
// Shared types, codes and constants of the voxel region editor.
package vreu_pkg;

    localparam int MAX_DIM_DEF = 32;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 6'd32;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_FILL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPECKLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECOLOR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 8;
    localparam int THR_W   = 17;
    localparam int SEED_W  = 32;
    localparam int COUNT_W = 16;
    localparam int HASH_W  = 32;
    localparam int HASH_LOW_W = 16;

    localparam int OFF_AX   = 0;
    localparam int OFF_AY   = 16;
    localparam int OFF_AZ   = 32;
    localparam int OFF_BX   = 48;
    localparam int OFF_BY   = 64;
    localparam int OFF_BZ   = 80;
    localparam int OFF_COL  = 96;
    localparam int OFF_FROM = 104;
    localparam int OFF_THR  = 112;
    localparam int OFF_SEED = 129;
    localparam int TDATA_W  = 168;

    localparam logic [HASH_W-1:0] HASH_PX  = 32'd73856093;
    localparam logic [HASH_W-1:0] HASH_PY  = 32'd19349663;
    localparam logic [HASH_W-1:0] HASH_PZ  = 32'd83492791;
    localparam logic [HASH_W-1:0] HASH_MUL = 32'h5bd1e995;
    localparam int HASH_SH1 = 13;
    localparam int HASH_SH2 = 15;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic setup1;
        logic setup2;
        logic setup3;
        logic step;
        logic load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic skip;
        logic last_cell;
        logic pipe_busy;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- design/vreu_ctrl.sv -----
// Sequencing state machine of the voxel region editor.
module vreu_ctrl
    import vreu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP1 = 3'd2;
    localparam logic [2:0] ST_SETUP2 = 3'd3;
    localparam logic [2:0] ST_SETUP3 = 3'd4;
    localparam logic [2:0] ST_SWEEP  = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_SETUP1;
                end
            end
            ST_SETUP1: begin
                o_cmd.setup1 = 1'b1;
                n_state = ST_SETUP2;
            end
            ST_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                n_state = ST_SETUP3;
            end
            ST_SETUP3: begin
                o_cmd.setup3 = 1'b1;
                n_state = i_status.skip ? ST_RESULT : ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_status.last_cell) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_result = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ----- design/vreu_datapath.sv -----
// Datapath of the voxel region editor: box set-up, cell sweep, store and count.
`include "voxel_region_editor_unit_macros.svh"

module vreu_datapath
    import vreu_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic [TDATA_W-1:0]   i_s_tdata,
    input  logic [KIND_W-1:0]    i_s_tuser,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [COUNT_W-1:0]   o_m_tdata
);

    localparam int CELLS  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CLIP_W = COORD_W + 2;

    typedef struct packed {
        logic             ok;
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
    } t_span;

    function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [DIM_W-1:0] e;
        if (32'(s) > MAX_DIM) begin
            e = DIM_W'(MAX_DIM);
        end else begin
            e = DIM_W'(s);
        end
        return e;
    endfunction

    function automatic t_span clip_axis(input logic signed [COORD_W-1:0] a,
                                        input logic signed [COORD_W-1:0] b,
                                        input logic [DIM_W-1:0] size);
        logic signed [CLIP_W-1:0] l;
        logic signed [CLIP_W-1:0] h;
        logic signed [CLIP_W-1:0] top;
        t_span s;
        l   = (a < b) ? {{2{a[COORD_W-1]}}, a} : {{2{b[COORD_W-1]}}, b};
        h   = (a < b) ? {{2{b[COORD_W-1]}}, b} : {{2{a[COORD_W-1]}}, a};
        top = {{(CLIP_W-DIM_W){1'b0}}, size} - CLIP_W'(1);
        if (l[CLIP_W-1]) begin
            l = '0;
        end
        if (h > top) begin
            h = top;
        end
        s.ok = !(l > h);
        s.lo = l[DIM_W-1:0];
        s.hi = h[DIM_W-1:0];
        return s;
    endfunction

    logic [CFG_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [DIM_W-1:0] w_sx, w_sy, w_sz;

    logic [KIND_W-1:0]         r_kind;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [COLOR_W-1:0]        r_color, r_from;
    logic [THR_W-1:0]          r_thr;
    logic [SEED_W-1:0]         r_seed;

    t_span w_span_x, w_span_y, w_span_z;
    logic             r_box_ok;
    logic [DIM_W-1:0] r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic [ADDR_W-1:0] r_stride_y, r_zoff;

    logic [DIM_W-1:0]  r_x, r_y, r_z;
    logic [ADDR_W-1:0] r_addr, r_row, r_plane;
    logic [ADDR_W-1:0] n_row, n_plane;

    logic [HASH_W-1:0] w_h0, w_h1;
    logic              r_p1_valid;
    logic [ADDR_W-1:0] r_p1_addr;
    logic [HASH_W-1:0] r_p1_h;
    logic [COLOR_W-1:0] r_rd_data;

    logic               r_p2_valid;
    logic [ADDR_W-1:0]  r_p2_addr;
    logic [COLOR_W-1:0] r_p2_old;
    logic [HASH_W-1:0]  r_p2_h;
    logic [HASH_W-1:0]  w_hf;
    logic               w_hit;
    logic               w_wr_en;

    logic [COLOR_W-1:0] r_voxel_mem [CELLS];
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= CFG_SIZE_RESET;
            r_size_y <= CFG_SIZE_RESET;
            r_size_z <= CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_sx = eff_size(r_size_x);
    assign w_sy = eff_size(r_size_y);
    assign w_sz = eff_size(r_size_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_s_tuser;
            r_ax    <= i_s_tdata[OFF_AX +: COORD_W];
            r_ay    <= i_s_tdata[OFF_AY +: COORD_W];
            r_az    <= i_s_tdata[OFF_AZ +: COORD_W];
            r_bx    <= i_s_tdata[OFF_BX +: COORD_W];
            r_by    <= i_s_tdata[OFF_BY +: COORD_W];
            r_bz    <= i_s_tdata[OFF_BZ +: COORD_W];
            r_color <= i_s_tdata[OFF_COL +: COLOR_W];
            r_from  <= i_s_tdata[OFF_FROM +: COLOR_W];
            r_thr   <= i_s_tdata[OFF_THR +: THR_W];
            r_seed  <= i_s_tdata[OFF_SEED +: SEED_W];
        end
    end

    assign w_span_x = clip_axis(r_ax, r_bx, w_sx);
    assign w_span_y = clip_axis(r_ay, r_by, w_sy);
    assign w_span_z = clip_axis(r_az, r_bz, w_sz);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup1) begin
            r_box_ok   <= w_span_x.ok && w_span_y.ok && w_span_z.ok;
            r_x0       <= w_span_x.lo;
            r_x1       <= w_span_x.hi;
            r_y0       <= w_span_y.lo;
            r_y1       <= w_span_y.hi;
            r_z0       <= w_span_z.lo;
            r_z1       <= w_span_z.hi;
            r_stride_y <= ADDR_W'(w_sx) * ADDR_W'(w_sz);
        end
        if (i_cmd.setup2) begin
            r_zoff <= ADDR_W'(r_z0) * ADDR_W'(w_sx);
        end
    end

    assign n_row   = r_row + ADDR_W'(w_sx);
    assign n_plane = r_plane + r_stride_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup3) begin
            r_x     <= r_x0;
            r_y     <= r_y0;
            r_z     <= r_z0;
            r_addr  <= ADDR_W'(r_y0) * r_stride_y + r_zoff + ADDR_W'(r_x0);
            r_row   <= ADDR_W'(r_y0) * r_stride_y + r_zoff + ADDR_W'(r_x0);
            r_plane <= ADDR_W'(r_y0) * r_stride_y + r_zoff + ADDR_W'(r_x0);
        end else if (i_cmd.step) begin
            if (r_x != r_x1) begin
                r_x    <= r_x + DIM_W'(1);
                r_addr <= r_addr + ADDR_W'(1);
            end else if (r_z != r_z1) begin
                r_x    <= r_x0;
                r_z    <= r_z + DIM_W'(1);
                r_row  <= n_row;
                r_addr <= n_row;
            end else begin
                r_x     <= r_x0;
                r_z     <= r_z0;
                r_y     <= r_y + DIM_W'(1);
                r_plane <= n_plane;
                r_row   <= n_plane;
                r_addr  <= n_plane;
            end
        end
    end

    assign w_h0 = r_seed ^ (HASH_W'(r_x) * HASH_PX) ^ (HASH_W'(r_y) * HASH_PY)
                ^ (HASH_W'(r_z) * HASH_PZ);
    assign w_h1 = w_h0 ^ (w_h0 >> HASH_SH1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.step;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr <= r_addr;
        r_p1_h    <= w_h1;
        r_p2_addr <= r_p1_addr;
        r_p2_old  <= r_rd_data;
        r_p2_h    <= r_p1_h * HASH_MUL;
    end

    assign w_hf  = r_p2_h ^ (r_p2_h >> HASH_SH2);
    assign w_hit = {1'b0, w_hf[HASH_LOW_W-1:0]} < r_thr;

    always_comb begin
        w_wr_en = 1'b0;
        if (r_p2_valid) begin
            case (r_kind)
                KIND_FILL:    w_wr_en = 1'b1;
                KIND_SPECKLE: w_wr_en = (r_p2_old != '0) && w_hit;
                KIND_RECOLOR: w_wr_en = (r_p2_old == r_from);
                default:      w_wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_voxel_mem[r_clr_addr] <= '0;
        end else if (w_wr_en) begin
            r_voxel_mem[r_p2_addr] <= r_color;
        end
        if (i_cmd.step) begin
            r_rd_data <= r_voxel_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            if ((r_p2_old != '0) && (r_color == '0)) begin
                r_count <= r_count - COUNT_W'(1);
            end else if ((r_p2_old == '0) && (r_color != '0)) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_data <= r_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_status.clear_last = (r_clr_addr == ADDR_W'(CELLS - 1));
    assign o_status.skip       = !r_box_ok || (r_kind == KIND_NONE);
    assign o_status.last_cell  = (r_x == r_x1) && (r_z == r_z1) && (r_y == r_y1);
    assign o_status.pipe_busy  = r_p1_valid || r_p2_valid;
    assign o_status.out_busy   = r_out_valid && !i_m_tready;

    `VREU_ASSERT_NXT(a_count_only_on_write, i_clk, i_rst_n, !r_p2_valid, $stable(r_count))
    `VREU_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, i_cmd.load_result, !r_out_valid || i_m_tready)
    `VREU_ASSERT_IMP(a_capture_after_drain, i_clk, i_rst_n, i_cmd.capture, !r_p1_valid && !r_p2_valid)

endmodule

// ----- design/voxel_region_editor_unit.sv -----
// Top level of the voxel region editor: controller and datapath.
//
// Commands arrive on the s_axis channel, one per transfer; the operation kind travels
// in tuser and the box corners, colours, threshold and seed in tdata. Each command
// yields one transfer on m_axis carrying the number of non-empty voxels.
// The sizes are written through the cfg channel, which is always ready; write them
// only while no command is outstanding.
// A command passes through the set-up states SETUP1, SETUP2 and SETUP3, sweeps
// the clipped box one voxel per cycle, waits for the store pipeline to drain and
// then loads the result; an empty box or an unused kind skips the sweep and drain.
// Commands are handled one at a time; the next is taken once the previous result
// sits in the output register. After reset the store is cleared one voxel a cycle,
// all MAX_DIM^3 voxels (32768 by default), during which s_axis_tready stays low.
// If the receiver stalls, the result is held and a following command is still
// processed; it waits for its own result until the held one has been taken.
module voxel_region_editor_unit
    import vreu_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // color, from_color, threshold, seed, zero padding
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // filled_count
    output logic [COUNT_W-1:0]   m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    vreu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vreu_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
